@@ src/csop_pkg.sv @@
// Shared types and constants for the column surface owner probe.
package csop_pkg;

  localparam logic [1:0] OP_WRITE_TILE  = 2'd0;
  localparam logic [1:0] OP_WRITE_ORDER = 2'd1;
  localparam logic [1:0] OP_PROBE       = 2'd2;

  localparam logic signed [15:0] TOP_SENTINEL = 16'sh7fff;
  localparam logic [4:0]         NO_OWNER     = 5'h1f;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 24;

  // request payload, first field in the high bits
  typedef struct packed {
    logic signed [15:0] column_x;
    logic [3:0]         order_entry;
    logic [15:0]        tile_height;
    logic [15:0]        tile_width;
    logic signed [15:0] tile_top;
    logic signed [15:0] tile_left;
    logic [3:0]         slot_index;
  } in_data_t;

  typedef struct packed {
    logic [2:0]         pad;
    logic [4:0]         owner_index;
    logic signed [15:0] surface_y;
  } out_data_t;

  typedef struct packed {
    logic [15:0]        height;
    logic [15:0]        width;
    logic signed [15:0] top;
    logic signed [15:0] left;
  } tile_t;

  typedef struct packed {
    logic tile_we;
    logic order_we;
    logic start;
    logic scan_issue;
    logic own_issue;
    logic cnt_clear;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cnt_done;
    logic covered;
    logic hit;
    logic busy;
    logic out_free;
  } status_t;

endpackage

@@ src/csop_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module csop_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/csop_ctrl.sv @@
// Sequencer for table writes and the two scan passes of a probe.
module csop_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [1:0]         s_tuser,
  input  csop_pkg::status_t  status,
  output csop_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_OWN   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.tile_we  = accept && (s_tuser == csop_pkg::OP_WRITE_TILE);
    cmd.order_we = accept && (s_tuser == csop_pkg::OP_WRITE_ORDER);
    case (state)
      S_IDLE: begin
        if (accept && s_tuser == csop_pkg::OP_PROBE) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.cnt_done) begin
          state_next = S_CHECK;
        end else begin
          cmd.scan_issue = 1'b1;
        end
      end
      S_CHECK: begin
        if (status.covered) begin
          cmd.cnt_clear = 1'b1;
          state_next    = S_OWN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_OWN: begin
        if (status.hit) begin
          state_next = S_DONE;
        end else if (!status.cnt_done) begin
          cmd.own_issue = 1'b1;
        end else if (!status.busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ src/csop_dp.sv @@
// Tile and order tables, scan counter, compare logic and result register.
module csop_dp #(
  parameter int MAX_TILES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [csop_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                              cfg_we,
  input  logic [4:0]                        cfg_wdata,
  input  csop_pkg::cmd_t                    cmd,
  output csop_pkg::status_t                 status,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [csop_pkg::OUT_DATA_W-1:0]   m_tdata
);

  localparam int IDX_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CW    = $clog2(MAX_TILES + 1);

  csop_pkg::in_data_t  din;
  csop_pkg::tile_t     tile_wr;
  csop_pkg::tile_t     tile_rd;
  csop_pkg::out_data_t dout;

  logic [4:0]         tile_count;
  logic [CW-1:0]      n;
  logic [CW-1:0]      cnt;
  logic [7:0]         count_ext;
  logic [7:0]         limit_ext;
  logic signed [15:0] x;
  logic signed [15:0] best;
  logic               found;
  logic               hit;
  logic [3:0]         owner;
  logic               v1;
  logic               ov;
  logic               tv;
  logic [3:0]         t_q;
  logic [3:0]         order_rdata;
  logic               slot_ok;
  logic               t_ok;
  logic [IDX_W-1:0]   tile_raddr;
  logic signed [17:0] x_s;
  logic signed [17:0] left_s;
  logic signed [17:0] right_s;
  logic signed [17:0] top_s;
  logic signed [17:0] bot_s;
  logic signed [17:0] best_s;
  logic               span;
  logic               vert;

  assign din       = csop_pkg::in_data_t'(s_tdata);
  assign slot_ok   = 8'(din.slot_index) < 8'(MAX_TILES);
  assign t_ok      = 8'(order_rdata) < 8'(MAX_TILES);
  assign count_ext = {3'b000, tile_count};
  assign limit_ext = 8'(MAX_TILES);

  assign tile_wr.height = din.tile_height;
  assign tile_wr.width  = din.tile_width;
  assign tile_wr.top    = din.tile_top;
  assign tile_wr.left   = din.tile_left;

  // the second pass addresses the tile table with the order slot contents
  assign tile_raddr = ov ? IDX_W'(order_rdata) : cnt[IDX_W-1:0];

  csop_ram #(.WIDTH($bits(csop_pkg::tile_t)), .DEPTH(MAX_TILES)) u_tile_ram (
    .clk   (clk),
    .we    (cmd.tile_we && slot_ok),
    .waddr (IDX_W'(din.slot_index)),
    .wdata (tile_wr),
    .raddr (tile_raddr),
    .rdata (tile_rd)
  );

  csop_ram #(.WIDTH(4), .DEPTH(MAX_TILES)) u_order_ram (
    .clk   (clk),
    .we    (cmd.order_we && slot_ok),
    .waddr (IDX_W'(din.slot_index)),
    .wdata (din.order_entry),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (order_rdata)
  );

  // edge sums at 18 bits never wrap
  always_comb begin
    x_s     = {{2{x[15]}}, x};
    left_s  = {{2{tile_rd.left[15]}}, tile_rd.left};
    right_s = left_s + {2'b00, tile_rd.width};
    top_s   = {{2{tile_rd.top[15]}}, tile_rd.top};
    bot_s   = top_s + {2'b00, tile_rd.height};
    best_s  = {{2{best[15]}}, best};
    span    = (x_s >= left_s) && (x_s < right_s);
    vert    = (best_s >= top_s) && (best_s < bot_s);
  end

  assign status.cnt_done = (cnt == n);
  assign status.covered  = found && (best != csop_pkg::TOP_SENTINEL);
  assign status.hit      = hit;
  assign status.busy     = ov || tv;
  assign status.out_free = !m_tvalid || m_tready;

  assign dout.pad         = '0;
  assign dout.surface_y   = status.covered ? best : 16'sd0;
  assign dout.owner_index = hit ? {1'b0, owner} : csop_pkg::NO_OWNER;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_count <= '0;
      found      <= 1'b0;
      hit        <= 1'b0;
      v1         <= 1'b0;
      ov         <= 1'b0;
      tv         <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        tile_count <= cfg_wdata;
      end
      v1 <= cmd.scan_issue;
      ov <= cmd.own_issue;
      tv <= ov && t_ok;
      if (cmd.start) begin
        found <= 1'b0;
        hit   <= 1'b0;
      end
      if (v1 && span && (!found || tile_rd.top < best)) begin
        found <= 1'b1;
      end
      if (tv && !hit && span && vert) begin
        hit <= 1'b1;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    t_q <= order_rdata;
    if (cmd.start) begin
      x <= din.column_x;
      n <= CW'((count_ext > limit_ext) ? limit_ext : count_ext);
    end
    if (cmd.start || cmd.cnt_clear) begin
      cnt <= '0;
    end else if (cmd.scan_issue || cmd.own_issue) begin
      cnt <= cnt + CW'(1);
    end
    if (v1 && span && (!found || tile_rd.top < best)) begin
      best <= tile_rd.top;
    end
    if (tv && !hit && span && vert) begin
      owner <= t_q;
    end
    if (cmd.out_load) begin
      m_tdata <= dout;
    end
  end

endmodule

@@ src/column_surface_owner_probe_top.sv @@
// Top level of the column surface owner probe.
//
// Input stream (s_*): s_tuser carries the operation. Tile writes and order
// slot writes give no result. A probe request gives one result on the
// output stream (m_*): the smallest top of the tiles covering column_x and
// the frontmost listed tile owning that point (all ones, NO_OWNER, if none;
// surface 0 and owner NO_OWNER if nothing covers the column). The tile
// table has one read port and is scanned over n entries, n being tile_count
// capped at MAX_TILES: once for the surface and once, through the order
// table, for the owner; the owner scan stops at the first hit. s_tready is
// low while a probe runs. A finished result waits in the output register
// while the next request is taken; a probe that finishes while the receiver
// stalls holds until the register frees. tile_count is written through
// cfg_we and cfg_wdata; write it only while the block is idle, which the
// block itself does not enforce. Reset clears tile_count and the handshake
// state; table contents are undefined until written.
module column_surface_owner_probe_top #(
  parameter int MAX_TILES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // slot_index, tile_left, tile_top, tile_width, tile_height,
  // order_entry, column_x
  input  logic [csop_pkg::IN_DATA_W-1:0]  s_tdata,
  // operation
  input  logic [1:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // surface_y, owner_index, zero pad
  output logic [csop_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic [4:0]                      cfg_wdata
);

  csop_pkg::cmd_t    cmd;
  csop_pkg::status_t status;

  csop_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  csop_dp #(.MAX_TILES(MAX_TILES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

@@ src/csop_checker.sv @@
// Port-level checks for the column surface owner probe, bound to the top.
module csop_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [1:0]                      s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [csop_pkg::OUT_DATA_W-1:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // owner is either none or a 4-bit tile index
  a_owner_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[20] |-> m_tdata[20:16] == csop_pkg::NO_OWNER)
    else $error("owner index out of range");

  // an accepted probe request closes the input
  a_probe_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == csop_pkg::OP_PROBE |=> !s_tready)
    else $error("input open during probe");

  // a new result only appears at the end of a probe
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result without probe");

  // the pad bits of every valid result are zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:21] == 3'b000)
    else $error("pad bits set");

endmodule

bind column_surface_owner_probe_top csop_checker u_csop_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
